/* sv/hsv_pkg.sv */
// hsv_pkg: shared widths, constants, sector codes and pipeline control type
// for the hsv to rgb converter. No dependencies.

package hsv_pkg;

   // field widths
   localparam int HUE_W  = 16;
   localparam int SAT_W  = 9;
   localparam int VAL_W  = 9;
   localparam int CHAN_W = 8;

   // default number of hue fraction bits
   localparam int HUE_FRAC_BITS_DEF = 6;

   // degrees in one sector, and 1.0 in Q1.8
   localparam int SECTOR_DEG = 60;
   localparam int ONE_Q8     = 256;

   // largest saturation that still counts as grey
   localparam logic [SAT_W-1:0] GREY_SAT_MAX = 9'd2;

   // full-scale channel
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

   // pipeline stages
   localparam int NUM_STAGES = 8;
   localparam int STG_DIV = 0;  // hue times reciprocal of the sector span
   localparam int STG_REM = 1;  // sector remainder and quotient fix-up
   localparam int STG_WGT = 2;  // sector code and p/q/t weights
   localparam int STG_MUL = 3;  // brightness times weight
   localparam int STG_SCL = 4;  // times 255, drop 16 fraction bits
   localparam int STG_EST = 5;  // quotient estimate by the span
   localparam int STG_FIX = 6;  // quotient fix-up and clamp
   localparam int STG_OUT = 7;  // channel arrangement, output register

   // hue sector codes
   typedef enum logic [2:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } hsv_sector_type;

   // per-stage load enables and valid flags
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } hsv_stage_ctrl_type;

endpackage

/* sv/hsv_if.sv */
// hsv_if: request and response channel interfaces with valid/ready handshake.
// Depends on hsv_pkg for field widths.

interface hsv_req_if import hsv_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [HUE_W-1:0] hue;
   logic [SAT_W-1:0] saturation;
   logic [VAL_W-1:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink (input valid, input hue, input saturation, input brightness,
                 output ready);
endinterface

interface hsv_rsp_if import hsv_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

/* sv/hsv_to_rgb_converter.sv */
// hsv_to_rgb_converter: top level of the hsv to rgb color converter.
// Depends on hsv_pkg, hsv_if, hsv_ctrl, hsv_sector and hsv_scale.
//
// Converts one color a clock unless the output stalls: hue in degrees with
// HUE_FRAC_BITS fraction bits, saturation and brightness in Q1.8, into
// 8-bit red, green and blue. The datapath is an eight-stage pipeline, and a
// new request can be accepted every cycle while the output is not stalled.
// Both divisions by the sixty-degree span (hue into sector, and the q/t
// channel scaling) are a reciprocal multiply followed by a one-step
// fix-up, each over two stages. Each stage holds while the one after it is
// full and stalled, so empty stages still fill while a response waits.

module hsv_to_rgb_converter import hsv_pkg::*; #(
   parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   hsv_req_if.sink    req_bus,
   hsv_rsp_if.source  rsp_bus
);

   localparam int SPAN = SECTOR_DEG << HUE_FRAC_BITS;
   localparam int FULL = ONE_Q8 * SPAN;
   localparam int A_W  = $clog2(FULL + 1);
   localparam int NP_W = VAL_W + SAT_W - 1;
   localparam int MP_W = NP_W + 8;

   hsv_stage_ctrl_type stage_ctrl;

   // pipeline control
   hsv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .out_ready (rsp_bus.ready),
      .in_ready  (req_bus.ready),
      .ctrl      (stage_ctrl)
   );

   // stages 1 to 3: sector and weights
   hsv_sector_type    sec3;
   logic              grey3;
   logic [VAL_W-1:0]  val3;
   logic [SAT_W-1:0]  pw3;
   logic [A_W-1:0]    qw3, tw3;

   hsv_sector #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_sector (
      .clock          (clock),
      .ctrl           (stage_ctrl),
      .hue            (req_bus.hue),
      .saturation     (req_bus.saturation),
      .brightness     (req_bus.brightness),
      .sector         (sec3),
      .grey           (grey3),
      .brightness_out (val3),
      .p_weight       (pw3),
      .q_weight       (qw3),
      .t_weight       (tw3)
   );

   // stages 4 to 7: q and t channels
   logic [CHAN_W-1:0] cq7, ct7;

   hsv_scale #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_scale_q (
      .clock      (clock),
      .ctrl       (stage_ctrl),
      .brightness (val3),
      .weight     (qw3),
      .chan       (cq7)
   );

   hsv_scale #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_scale_t (
      .clock      (clock),
      .ctrl       (stage_ctrl),
      .brightness (val3),
      .weight     (tw3),
      .chan       (ct7)
   );

   // stage 4: v channel and brightness times p weight
   logic [16:0]       mv4;
   logic [CHAN_W-1:0] cv4_in, cv4_ff;
   logic [NP_W-1:0]   np4_in, np4_ff;
   hsv_sector_type    sec4_ff;
   logic              grey4_ff;

   always_comb begin
      mv4    = (17'(val3) << 8) - 17'(val3);
      cv4_in = mv4[16] ? CHAN_MAX : mv4[15:8];
      np4_in = NP_W'(val3) * NP_W'(pw3);
   end

   always_ff @(posedge clock) begin
      if (stage_ctrl.load[STG_MUL]) begin
         cv4_ff   <= cv4_in;
         np4_ff   <= np4_in;
         sec4_ff  <= sec3;
         grey4_ff <= grey3;
      end
   end

   // stage 5: p channel, times 255 and drop 16 fraction bits
   logic [MP_W-1:0]   mp5;
   logic [CHAN_W-1:0] cp5_in, cp5_ff, cv5_ff;
   hsv_sector_type    sec5_ff;
   logic              grey5_ff;

   always_comb begin
      mp5    = (MP_W'(np4_ff) << 8) - MP_W'(np4_ff);
      cp5_in = mp5[MP_W-1] ? CHAN_MAX : mp5[MP_W-2:16];
   end

   always_ff @(posedge clock) begin
      if (stage_ctrl.load[STG_SCL]) begin
         cp5_ff   <= cp5_in;
         cv5_ff   <= cv4_ff;
         sec5_ff  <= sec4_ff;
         grey5_ff <= grey4_ff;
      end
   end

   // stages 6 and 7: keep v, p and sector aligned with q and t
   logic [CHAN_W-1:0] cp6_ff, cv6_ff, cp7_ff, cv7_ff;
   hsv_sector_type    sec6_ff, sec7_ff;
   logic              grey6_ff, grey7_ff;

   always_ff @(posedge clock) begin
      if (stage_ctrl.load[STG_EST]) begin
         cp6_ff   <= cp5_ff;
         cv6_ff   <= cv5_ff;
         sec6_ff  <= sec5_ff;
         grey6_ff <= grey5_ff;
      end
      if (stage_ctrl.load[STG_FIX]) begin
         cp7_ff   <= cp6_ff;
         cv7_ff   <= cv6_ff;
         sec7_ff  <= sec6_ff;
         grey7_ff <= grey6_ff;
      end
   end

   // stage 8: arrange channels by sector, grey overrides
   logic [CHAN_W-1:0] red_in, green_in, blue_in;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;

   always_comb begin
      case (sec7_ff)
         SEC_RED: begin
            red_in = cv7_ff; green_in = ct7;    blue_in = cp7_ff;
         end
         SEC_YELLOW: begin
            red_in = cq7;    green_in = cv7_ff; blue_in = cp7_ff;
         end
         SEC_GREEN: begin
            red_in = cp7_ff; green_in = cv7_ff; blue_in = ct7;
         end
         SEC_CYAN: begin
            red_in = cp7_ff; green_in = cq7;    blue_in = cv7_ff;
         end
         SEC_BLUE: begin
            red_in = ct7;    green_in = cp7_ff; blue_in = cv7_ff;
         end
         default: begin
            red_in = cv7_ff; green_in = cp7_ff; blue_in = cq7;
         end
      endcase
      if (grey7_ff) begin
         red_in   = cv7_ff;
         green_in = cv7_ff;
         blue_in  = cv7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ctrl.load[STG_OUT]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_bus.valid = stage_ctrl.valid[STG_OUT];
   assign rsp_bus.red   = red_ff;
   assign rsp_bus.green = green_ff;
   assign rsp_bus.blue  = blue_ff;

endmodule

/* sv/hsv_ctrl.sv */
// hsv_ctrl: valid bits of the pipeline and per-stage load enables; a stage
// loads when it is empty or the stage after it moves. Depends on hsv_pkg.

module hsv_ctrl import hsv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               out_ready,
   output logic               in_ready,
   output hsv_stage_ctrl_type ctrl
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   // load enables ripple back from the output
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   // next valid flags
   always_comb begin
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready   = load[0];
   assign ctrl.load  = load;
   assign ctrl.valid = valid_ff;

endmodule

/* sv/hsv_sector.sv */
// hsv_sector: first three stages; splits hue into sector and remainder by a
// reciprocal multiply with one fix-up, then forms the p, q and t weights.
// Depends on hsv_pkg.

module hsv_sector import hsv_pkg::*; #(
   parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
   localparam int SPAN   = SECTOR_DEG << HUE_FRAC_BITS,
   localparam int SPAN_W = $clog2(SPAN + 1),
   localparam int FULL   = ONE_Q8 * SPAN,
   localparam int A_W    = $clog2(FULL + 1)
) (
   input  logic               clock,
   input  hsv_stage_ctrl_type ctrl,
   input  logic [HUE_W-1:0]   hue,
   input  logic [SAT_W-1:0]   saturation,
   input  logic [VAL_W-1:0]   brightness,
   output hsv_sector_type     sector,
   output logic               grey,
   output logic [VAL_W-1:0]   brightness_out,
   output logic [SAT_W-1:0]   p_weight,
   output logic [A_W-1:0]     q_weight,
   output logic [A_W-1:0]     t_weight
);

   localparam int RECIP_H = (1 << HUE_W) / SPAN;
   localparam int QH_W    = $clog2(RECIP_H + 2);
   localparam int PH_W    = HUE_W + QH_W;
   localparam int SR_W    = SAT_W + SPAN_W;

   // stage 1: quotient estimate
   logic [PH_W-1:0]  quo_prod;
   logic [QH_W-1:0]  quo1_in, quo1_ff;
   logic [HUE_W-1:0] hue1_ff;
   logic [SAT_W-1:0] sat1_ff;
   logic [VAL_W-1:0] val1_ff;

   always_comb begin
      quo_prod = PH_W'(hue) * PH_W'(RECIP_H);
      quo1_in  = quo_prod[PH_W-1:HUE_W];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_DIV]) begin
         quo1_ff <= quo1_in;
         hue1_ff <= hue;
         sat1_ff <= saturation;
         val1_ff <= brightness;
      end
   end

   // stage 2: remainder, estimate may be one short
   logic [HUE_W-1:0]  base2;
   logic [HUE_W-1:0]  rem_raw;
   logic              rem_fix;
   logic [SPAN_W-1:0] rem2_in, rem2_ff;
   logic [QH_W-1:0]   quo2_in, quo2_ff;
   logic [SAT_W-1:0]  sat2_ff;
   logic [VAL_W-1:0]  val2_ff;

   always_comb begin
      base2   = HUE_W'(PH_W'(quo1_ff) * PH_W'(SPAN));
      rem_raw = hue1_ff - base2;
      rem_fix = rem_raw >= HUE_W'(SPAN);
      rem2_in = rem_fix ? SPAN_W'(rem_raw - HUE_W'(SPAN)) : SPAN_W'(rem_raw);
      quo2_in = quo1_ff + QH_W'(rem_fix);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_REM]) begin
         rem2_ff <= rem2_in;
         quo2_ff <= quo2_in;
         sat2_ff <= sat1_ff;
         val2_ff <= val1_ff;
      end
   end

   // stage 3: sector code, wrap once, clamp to the last sector
   logic [31:0]       quo_ext;
   hsv_sector_type    sec3_in, sec3_ff;
   logic [SPAN_W-1:0] comp;
   logic [SR_W-1:0]   sr_q, sr_t;
   logic [A_W-1:0]    aq3_in, aq3_ff, at3_in, at3_ff;
   logic [SAT_W-1:0]  pw3_in, pw3_ff;
   logic              grey3_in, grey3_ff;
   logic [VAL_W-1:0]  val3_ff;

   always_comb begin
      quo_ext = 32'(quo2_ff);
      if (quo_ext < 32'd6) begin
         sec3_in = hsv_sector_type'(3'(quo_ext));
      end else if (quo_ext < 32'd12) begin
         sec3_in = hsv_sector_type'(3'(quo_ext - 32'd6));
      end else begin
         sec3_in = SEC_MAGENTA;
      end
   end

   // weights: full - s*f and full - s*(1-f), zero when not positive
   always_comb begin
      comp     = SPAN_W'(SPAN) - rem2_ff;
      sr_q     = SR_W'(sat2_ff) * SR_W'(rem2_ff);
      sr_t     = SR_W'(sat2_ff) * SR_W'(comp);
      aq3_in   = (sr_q < SR_W'(FULL)) ? A_W'(SR_W'(FULL) - sr_q) : '0;
      at3_in   = (sr_t < SR_W'(FULL)) ? A_W'(SR_W'(FULL) - sr_t) : '0;
      pw3_in   = (sat2_ff < SAT_W'(ONE_Q8)) ? SAT_W'(ONE_Q8) - sat2_ff : '0;
      grey3_in = sat2_ff <= GREY_SAT_MAX;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_WGT]) begin
         sec3_ff  <= sec3_in;
         aq3_ff   <= aq3_in;
         at3_ff   <= at3_in;
         pw3_ff   <= pw3_in;
         grey3_ff <= grey3_in;
         val3_ff  <= val2_ff;
      end
   end

   assign sector         = sec3_ff;
   assign grey           = grey3_ff;
   assign brightness_out = val3_ff;
   assign p_weight       = pw3_ff;
   assign q_weight       = aq3_ff;
   assign t_weight       = at3_ff;

endmodule

/* sv/hsv_scale.sv */
// hsv_scale: stages four to seven for one hue-dependent channel; computes
// floor(v * w * 255 / (65536 * span)) clamped to 255. Depends on hsv_pkg.

module hsv_scale import hsv_pkg::*; #(
   parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
   localparam int SPAN = SECTOR_DEG << HUE_FRAC_BITS,
   localparam int FULL = ONE_Q8 * SPAN,
   localparam int A_W  = $clog2(FULL + 1)
) (
   input  logic               clock,
   input  hsv_stage_ctrl_type ctrl,
   input  logic [VAL_W-1:0]   brightness,
   input  logic [A_W-1:0]     weight,
   output logic [CHAN_W-1:0]  chan
);

   localparam int N_W     = VAL_W + A_W;
   localparam int M_W     = N_W + 8;
   localparam int Y_W     = M_W - 16;
   localparam int RECIP_Y = (1 << A_W) / SPAN;
   localparam int RY_W    = $clog2(RECIP_Y + 1);
   localparam int E_W     = A_W + RY_W;

   // stage 4: brightness times weight
   logic [N_W-1:0] prod4_in, prod4_ff;

   assign prod4_in = N_W'(brightness) * N_W'(weight);

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_MUL]) begin
         prod4_ff <= prod4_in;
      end
   end

   // stage 5: times 255 as shift and subtract, drop 16 fraction bits
   logic [M_W-1:0] m5;
   logic [Y_W-1:0] y5;
   logic [A_W-1:0] y5_in, y5_ff;
   logic           sat5_in, sat5_ff;

   always_comb begin
      m5      = (M_W'(prod4_ff) << 8) - M_W'(prod4_ff);
      y5      = m5[M_W-1:16];
      sat5_in = y5 >= Y_W'(FULL);
      y5_in   = A_W'(y5);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_SCL]) begin
         y5_ff   <= y5_in;
         sat5_ff <= sat5_in;
      end
   end

   // stage 6: quotient estimate by reciprocal of the span
   logic [E_W-1:0]    est_prod;
   logic [CHAN_W-1:0] est6_in, est6_ff;
   logic [A_W-1:0]    y6_ff;
   logic              sat6_ff;

   always_comb begin
      est_prod = E_W'(y5_ff) * E_W'(RECIP_Y);
      est6_in  = est_prod[A_W +: CHAN_W];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_EST]) begin
         est6_ff <= est6_in;
         y6_ff   <= y5_ff;
         sat6_ff <= sat5_ff;
      end
   end

   // stage 7: estimate may be one short, then clamp
   logic [A_W-1:0]    back7;
   logic [A_W-1:0]    rem7;
   logic              fix7;
   logic [CHAN_W-1:0] chan7_in, chan7_ff;

   always_comb begin
      back7    = A_W'(A_W'(est6_ff) * A_W'(SPAN));
      rem7     = y6_ff - back7;
      fix7     = rem7 >= A_W'(SPAN);
      chan7_in = sat6_ff ? CHAN_MAX : est6_ff + CHAN_W'(fix7);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_FIX]) begin
         chan7_ff <= chan7_in;
      end
   end

   assign chan = chan7_ff;

endmodule

/* sim/testbench.sv */
// testbench: self-checking bench for hsv_to_rgb_converter, with a clocked driver,
// a monitor and a color predictor built into the top module.
// Depends on hsv_pkg, hsv_if (hsv_req_if, hsv_rsp_if) and the converter RTL.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hsv_pkg::*;

   localparam int     HALF_PERIOD   = 4;
   localparam int     RESET_CYCLES  = 8;
   localparam int     HUE_FRAC      = HUE_FRAC_BITS_DEF;
   localparam longint SPAN          = SECTOR_DEG * (1 << HUE_FRAC);
   localparam int     HUE_LIMIT     = 12 * SECTOR_DEG * (1 << HUE_FRAC) - 1;
   localparam int     RANDOM_COLORS = 1300;
   localparam int     IDLE_PCT      = 35;
   localparam int     CALM_FIRST    = 400;
   localparam int     CALM_LAST     = 650;
   localparam int     HOLD_AT       = 900;
   localparam int     HOLD_CYCLES   = 80;
   localparam int     DRAIN_CYCLES  = 3 * NUM_STAGES;
   localparam int     MAX_REPORTS   = 10;
   localparam int     TIMEOUT_NS    = 2_000_000;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [SAT_W-1:0] saturation;
      logic [VAL_W-1:0] brightness;
   } color_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hsv_req_if req_bus ();
   hsv_rsp_if rsp_bus ();

   hsv_to_rgb_converter #(
      .HUE_FRAC_BITS(HUE_FRAC)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   color_req_type pending_colors[$];
   rgb_type       expected_rgb[$];
   int         colors_sent    = 0;
   int         colors_checked = 0;
   int         mismatch_count = 0;
   logic       req_taken      = 1'b0;
   logic       hold_rsp       = 1'b0;
   logic       calm_send;
   logic       calm_recv;

   assign calm_send = (colors_sent >= CALM_FIRST) && (colors_sent < CALM_LAST);
   assign calm_recv = (colors_checked >= CALM_FIRST) && (colors_checked < CALM_LAST);

   // clock
   always #HALF_PERIOD clock = ~clock;

   // floor(num * 255 / den), clamped to the channel range
   function automatic logic [CHAN_W-1:0] scale_channel(longint num, longint den);
      longint r;
      if (num <= 0 || den <= 0) return '0;
      r = (num * 255) / den;
      if (r > 255) r = 255;
      return r[CHAN_W-1:0];
   endfunction

   // expected rgb for one hsv request
   function automatic rgb_type predict_rgb(color_req_type c);
      longint         hue, sat, val, sector, rem, full_scale;
      logic [CHAN_W-1:0] cv, cp, cq, ct;
      hsv_sector_type sec;
      rgb_type        rgb;
      hue = longint'(c.hue);
      sat = longint'(c.saturation);
      val = longint'(c.brightness);
      cv  = scale_channel(val, ONE_Q8);
      // near-zero saturation is plain grey
      if (c.saturation <= GREY_SAT_MAX) begin
         rgb.red   = cv;
         rgb.green = cv;
         rgb.blue  = cv;
         return rgb;
      end
      sector = hue / SPAN;
      rem    = hue % SPAN;
      // one turn folded back, anything still beyond uses the magenta sector
      if (sector >= 6) sector -= 6;
      if (sector > 5) sector = 5;
      sec        = hsv_sector_type'(sector[2:0]);
      full_scale = ONE_Q8 * SPAN;
      cp = scale_channel(val * (ONE_Q8 - sat), ONE_Q8 * ONE_Q8);
      cq = scale_channel(val * (full_scale - sat * rem), ONE_Q8 * ONE_Q8 * SPAN);
      ct = scale_channel(val * (full_scale - sat * (SPAN - rem)), ONE_Q8 * ONE_Q8 * SPAN);
      case (sec)
         SEC_RED: begin
            rgb = '{cv, ct, cp};
         end
         SEC_YELLOW: begin
            rgb = '{cq, cv, cp};
         end
         SEC_GREEN: begin
            rgb = '{cp, cv, ct};
         end
         SEC_CYAN: begin
            rgb = '{cp, cq, cv};
         end
         SEC_BLUE: begin
            rgb = '{ct, cp, cv};
         end
         default: begin
            rgb = '{cv, cp, cq};
         end
      endcase
      return rgb;
   endfunction

   task automatic queue_color(int hue, int sat, int val);
      color_req_type c;
      c.hue        = hue[HUE_W-1:0];
      c.saturation = sat[SAT_W-1:0];
      c.brightness = val[VAL_W-1:0];
      pending_colors.push_back(c);
   endtask

   task automatic report_failure(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("testbench: %s", what);
   endtask

   // known values on every input from the start
   initial begin
      req_bus.valid      = 1'b0;
      req_bus.hue        = '0;
      req_bus.saturation = '0;
      req_bus.brightness = '0;
      rsp_bus.ready      = 1'b0;
   end

   // request driver, fed from the pending queue
   always @(negedge clock) begin : drive_colors
      color_req_type next_color;
      logic       offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_taken = 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         req_taken = 1'b0;
         offer = (pending_colors.size() != 0)
                 && (calm_send || $urandom_range(99) >= IDLE_PCT);
         if (offer) begin
            next_color = pending_colors.pop_front();
            req_bus.hue        <= next_color.hue;
            req_bus.saturation <= next_color.saturation;
            req_bus.brightness <= next_color.brightness;
         end
         req_bus.valid <= offer;
      end
   end

   // response ready with random stalls and the long hold-off
   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm_recv || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin : check_rgb
      color_req_type seen;
      rgb_type       want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen.hue        = req_bus.hue;
            seen.saturation = req_bus.saturation;
            seen.brightness = req_bus.brightness;
            expected_rgb.push_back(predict_rgb(seen));
            req_taken = 1'b1;
            colors_sent++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rgb.size() == 0) begin
               report_failure($sformatf("response %0h/%0h/%0h with no request waiting",
                                        rsp_bus.red, rsp_bus.green, rsp_bus.blue));
            end else begin
               want = expected_rgb.pop_front();
               if (rsp_bus.red !== want.red || rsp_bus.green !== want.green
                   || rsp_bus.blue !== want.blue) begin
                  report_failure($sformatf(
                     "mismatch on color %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     colors_checked, want.red, want.green, want.blue,
                     rsp_bus.red, rsp_bus.green, rsp_bus.blue));
               end
               colors_checked++;
            end
         end
      end
   end

   // long receiver hold-off so the pipeline fills and stalls its input
   initial begin
      int held;
      held = 0;
      while (colors_checked < HOLD_AT) @(posedge clock);
      hold_rsp = 1'b1;
      while (held < HOLD_CYCLES) begin
         @(posedge clock);
         held++;
      end
      hold_rsp = 1'b0;
   end

   // stimulus and end of run
   initial begin
      color_req_type c;
      int            pick;

      // directed: extremes, every sector, grey threshold, saturating channels
      queue_color(0, ONE_Q8, ONE_Q8);
      for (int k = 0; k < 6; k++) queue_color(int'(k * SPAN + SPAN / 2), ONE_Q8, ONE_Q8);
      queue_color(int'(SPAN - 1), ONE_Q8, ONE_Q8);
      queue_color(HUE_LIMIT, ONE_Q8, ONE_Q8);
      queue_color(int'(6 * SPAN), 200, 200);
      queue_color(50000, 128, 200);
      queue_color(65535, ONE_Q8, ONE_Q8);
      queue_color(1000, 0, ONE_Q8);
      queue_color(1000, int'(GREY_SAT_MAX), ONE_Q8);
      queue_color(1000, int'(GREY_SAT_MAX) + 1, ONE_Q8);
      queue_color(5000, ONE_Q8, 0);
      queue_color(7000, 100, 511);
      queue_color(9000, 511, ONE_Q8);
      queue_color(65535, 511, 511);
      queue_color(0, int'(GREY_SAT_MAX), 511);
      queue_color(int'(2 * SPAN), 511, 0);

      // random: mostly in-range colors, some near grey, some full-width noise
      for (int n = 0; n < RANDOM_COLORS; n++) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            c.hue        = HUE_W'($urandom_range(HUE_LIMIT));
            c.saturation = SAT_W'($urandom_range(ONE_Q8));
            c.brightness = VAL_W'($urandom_range(ONE_Q8));
         end else if (pick < 80) begin
            c.hue        = HUE_W'($urandom_range(HUE_LIMIT));
            c.saturation = SAT_W'($urandom_range(5));
            c.brightness = VAL_W'($urandom_range(511));
         end else begin
            c.hue        = HUE_W'($urandom);
            c.saturation = SAT_W'($urandom);
            c.brightness = VAL_W'($urandom);
         end
         pending_colors.push_back(c);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_colors.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_rgb.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("testbench: %0d colors sent, %0d checked, %0d failures", colors_sent,
               colors_checked, mismatch_count);
      $display("testbench: covered grey, all six sectors, hue past one turn, clamped channels");
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("testbench: timeout");
      $display("testbench: done, errors");
      $finish;
   end

endmodule

/* sim.f */
sv/hsv_pkg.sv
sv/hsv_if.sv
sv/hsv_ctrl.sv
sv/hsv_sector.sv
sv/hsv_scale.sv
sv/hsv_to_rgb_converter.sv
sim/testbench.sv
